FILE: rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

FILE: rtl/mlfq_pkg.sv
`timescale 1ns / 1ps
package mlfq_pkg;
  localparam int MaxProcsDef = 16;
  localparam int LevelCount = 3;
  localparam logic [15:0] TimeLimit = 16'hFFFF;
  localparam logic [7:0] Q0Reset = 8'd2;
  localparam logic [7:0] Q1Reset = 8'd4;
  localparam logic [7:0] Q2Reset = 8'd8;

  localparam logic [1:0] CfgQ0 = 2'd0;
  localparam logic [1:0] CfgQ1 = 2'd1;
  localparam logic [1:0] CfgQ2 = 2'd2;

  localparam logic [2:0] StLoaded = 3'd0;
  localparam logic [2:0] StFull = 3'd1;
  localparam logic [2:0] StIdle = 3'd2;
  localparam logic [2:0] StRun = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  localparam logic OpLoad = 1'b0;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
  } sub_req_t;
endpackage

FILE: rtl/mlfq_alu.sv
`timescale 1ns / 1ps
module mlfq_alu (
  input  mlfq_pkg::sub_req_t req_i,
  output logic [16:0]        diff_o,
  output logic               lt_o
);
  import mlfq_pkg::*;
  assign diff_o = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign lt_o = diff_o[16];
endmodule

FILE: rtl/mlfq_three_level_scheduler.sv
`timescale 1ns / 1ps
// Three-level feedback-queue scheduler.
// Input: start with operation_i; accepted when start is high and busy low.
// op 0 loads tag, arrival and burst into the next table slot; op 1 runs one
// scheduling step: admit arrivals, dispatch the head of the highest busy
// level for min(remaining, quantum), admit again, requeue or finish.
// Each transaction yields one result, shown for one cycle with done_o high.
// A step scans the loaded slots twice through one shared subtract/compare
// unit. The result strobe comes in the cycle after the last busy cycle,
// and the next item can be taken at the edge that ends the strobe cycle.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write quanta; the user must
// write them only while idle, which the block itself does not enforce.
// Reset clears counters, time, flags and queue pointers and loads quanta
// 2, 4, 8. The receiver cannot stall; results must be taken as shown.
`include "assert_macros.svh"
module mlfq_three_level_scheduler #(
  parameter int MAX_PROCS = mlfq_pkg::MaxProcsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        operation_i,
  input  logic [7:0]  process_tag_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_time_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic [7:0]  dispatched_tag_o,
  output logic [7:0]  slice_length_o,
  output logic [1:0]  level_run_o,
  output logic        finished_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic [15:0] time_now_o
);
  import mlfq_pkg::*;
  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int FAW = $clog2(LevelCount * MAX_PROCS);
  localparam logic [CW-1:0] MaxC = CW'(MAX_PROCS);
  localparam logic [SW-1:0] LastS = SW'(MAX_PROCS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SCAN, S_SCAN_RD, S_PICK, S_POP, S_RUN, S_TIME,
    S_SCAN2, S_SCAN2_RD, S_FIN, S_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0] q0_q, q1_q, q2_q;
  logic [15:0] arr_mem [MAX_PROCS];
  logic [15:0] bur_mem [MAX_PROCS];
  logic [15:0] rem_mem [MAX_PROCS];
  logic [7:0]  tag_mem [MAX_PROCS];
  logic [SW-1:0] fifo_mem [LevelCount*MAX_PROCS];
  logic [MAX_PROCS-1:0] adm_q;
  logic [SW-1:0] head_q [LevelCount];
  logic [CW-1:0] cnt_q [LevelCount];
  logic [CW-1:0] loaded_q, compl_q;
  logic [15:0] time_q;
  logic [CW-1:0] idx_q;
  logic [15:0] rd_arr_q, rd_rem_q, rd_bur_q;
  logic [7:0] rd_tag_q;
  logic [SW-1:0] slot_q;
  logic [1:0] lvl_q;
  logic [7:0] slice_q, quant_q;
  logic [15:0] turn_q;
  logic op_q;
  logic [7:0] in_tag_q;
  logic [15:0] in_arr_q, in_bur_q;
  logic [2:0] st_q;
  logic fin_q;

  sub_req_t req;
  logic [16:0] diff;
  logic lt;
  mlfq_alu u_alu (.req_i(req), .diff_o(diff), .lt_o(lt));

  always_comb begin
    req.a = 16'd0;
    req.b = 16'd0;
    case (state_q)
      S_SCAN_RD, S_SCAN2_RD: begin
        req.a = time_q;
        req.b = rd_arr_q;
      end
      S_RUN: begin
        req.a = rd_rem_q;
        req.b = {8'd0, quant_q};
      end
      S_TIME: begin
        req.a = TimeLimit - time_q;
        req.b = {8'd0, slice_q};
      end
      S_FIN: begin
        req.a = time_q;
        req.b = rd_arr_q;
      end
      S_WAIT: begin
        req.a = turn_q;
        req.b = rd_bur_q;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != S_IDLE);
  logic [SW-1:0] idx_s;
  assign idx_s = idx_q[SW-1:0];

  function automatic logic [7:0] fixq(input logic [7:0] q);
    return (q == 8'd0) ? 8'd1 : q;
  endfunction

  function automatic logic [FAW-1:0] faddr(input logic [1:0] l, input logic [SW-1:0] p);
    return FAW'(int'(l) * MAX_PROCS + int'(p));
  endfunction

  function automatic logic [SW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = (v >= (CW+1)'(MAX_PROCS)) ? v - (CW+1)'(MAX_PROCS) : v;
    return r[SW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && op_q == OpLoad && loaded_q < MaxC) begin
      arr_mem[loaded_q[SW-1:0]] <= in_arr_q;
      bur_mem[loaded_q[SW-1:0]] <= in_bur_q;
      rem_mem[loaded_q[SW-1:0]] <= in_bur_q;
      tag_mem[loaded_q[SW-1:0]] <= in_tag_q;
    end
    if (state_q == S_RUN && idx_q == '1)
      rem_mem[slot_q] <= lt ? 16'd0 : diff[15:0];
    rd_arr_q <= arr_mem[(state_q == S_SCAN || state_q == S_SCAN2) ? idx_s : slot_q];
    rd_rem_q <= rem_mem[slot_q];
    rd_bur_q <= bur_mem[slot_q];
    rd_tag_q <= tag_mem[slot_q];
  end

  logic push_scan;
  assign push_scan = (state_q == S_SCAN_RD || state_q == S_SCAN2_RD) && !lt
                     && !adm_q[idx_s] && cnt_q[0] < MaxC;
  logic [1:0] req_lvl;
  assign req_lvl = (lvl_q < 2'd2) ? lvl_q + 2'd1 : 2'd2;
  logic requeue;
  assign requeue = (state_q == S_FIN) && (rd_rem_q != 16'd0)
                   && cnt_q[req_lvl] < MaxC;
  logic [SW-1:0] fifo_rd_q;

  always_ff @(posedge clk_i) begin
    if (push_scan)
      fifo_mem[faddr(2'd0, wrap({1'b0, CW'(head_q[0])} + {1'b0, cnt_q[0]}))] <= idx_s;
    else if (requeue)
      fifo_mem[faddr(req_lvl, wrap({1'b0, CW'(head_q[req_lvl])} + {1'b0, cnt_q[req_lvl]}))]
        <= slot_q;
    fifo_rd_q <= fifo_mem[faddr(lvl_q, head_q[lvl_q])];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      q0_q <= Q0Reset;
      q1_q <= Q1Reset;
      q2_q <= Q2Reset;
      adm_q <= '0;
      for (int l = 0; l < LevelCount; l++) begin
        head_q[l] <= '0;
        cnt_q[l] <= '0;
      end
      loaded_q <= '0;
      compl_q <= '0;
      time_q <= '0;
      idx_q <= '0;
      done_o <= 1'b0;
      lvl_q <= '0;
      slot_q <= '0;
      slice_q <= '0;
      quant_q <= '0;
      turn_q <= '0;
      op_q <= 1'b0;
      st_q <= '0;
      fin_q <= 1'b0;
      in_tag_q <= '0;
      in_arr_q <= '0;
      in_bur_q <= '0;
      status_o <= '0;
      slot_index_o <= '0;
      dispatched_tag_o <= '0;
      slice_length_o <= '0;
      level_run_o <= '0;
      finished_o <= 1'b0;
      turnaround_o <= '0;
      waiting_o <= '0;
      time_now_o <= '0;
    end else begin
      done_o <= (state_q == S_OUT);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgQ0: q0_q <= cfg_data_i;
          CfgQ1: q1_q <= cfg_data_i;
          CfgQ2: q2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_scan)
        cnt_q[0] <= cnt_q[0] + 1'b1;
      if ((state_q == S_SCAN_RD || state_q == S_SCAN2_RD) && !lt && !adm_q[idx_s])
        adm_q[idx_s] <= 1'b1;
      if (requeue)
        cnt_q[req_lvl] <= cnt_q[req_lvl] + 1'b1;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q <= operation_i;
            in_tag_q <= process_tag_i;
            in_arr_q <= arrival_time_i;
            in_bur_q <= burst_time_i;
            slot_q <= '0;
            lvl_q <= '0;
            slice_q <= '0;
            fin_q <= 1'b0;
            turn_q <= '0;
            idx_q <= '0;
            if (operation_i == OpLoad) state_q <= S_LOAD;
            else if (compl_q >= loaded_q) begin
              st_q <= StDone;
              state_q <= S_OUT;
            end else state_q <= (loaded_q == '0) ? S_PICK : S_SCAN;
          end
        end
        S_LOAD: begin
          if (loaded_q < MaxC) begin
            slot_q <= loaded_q[SW-1:0];
            adm_q[loaded_q[SW-1:0]] <= 1'b0;
            loaded_q <= loaded_q + 1'b1;
            st_q <= StLoaded;
          end else st_q <= StFull;
          state_q <= S_OUT;
        end
        S_SCAN: state_q <= S_SCAN_RD;
        S_SCAN_RD, S_SCAN2_RD: begin
          if (idx_q + 1'b1 >= loaded_q || idx_s == LastS)
            state_q <= (state_q == S_SCAN_RD) ? S_PICK : S_FIN;
          else begin
            idx_q <= idx_q + 1'b1;
            state_q <= (state_q == S_SCAN_RD) ? S_SCAN : S_SCAN2;
          end
        end
        S_PICK: begin
          if (cnt_q[0] != '0) begin
            lvl_q <= 2'd0;
            quant_q <= fixq(q0_q);
            state_q <= S_POP;
          end else if (cnt_q[1] != '0) begin
            lvl_q <= 2'd1;
            quant_q <= fixq(q1_q);
            state_q <= S_POP;
          end else if (cnt_q[2] != '0) begin
            lvl_q <= 2'd2;
            quant_q <= fixq(q2_q);
            state_q <= S_POP;
          end else begin
            if (time_q != TimeLimit) time_q <= time_q + 1'b1;
            st_q <= StIdle;
            state_q <= S_OUT;
          end
        end
        S_POP: begin
          if (idx_q == '1) begin
            slot_q <= fifo_rd_q;
            head_q[lvl_q] <= wrap({1'b0, CW'(head_q[lvl_q])} + 1'b1);
            cnt_q[lvl_q] <= cnt_q[lvl_q] - 1'b1;
            idx_q <= '0;
            state_q <= S_RUN;
          end else idx_q <= '1;
        end
        S_RUN: begin
          if (idx_q == '1) begin
            slice_q <= lt ? rd_rem_q[7:0] : quant_q;
            idx_q <= '0;
            state_q <= S_TIME;
          end else idx_q <= '1;
        end
        S_TIME: begin
          time_q <= lt ? TimeLimit : time_q + {8'd0, slice_q};
          idx_q <= '0;
          state_q <= (loaded_q == '0) ? S_FIN : S_SCAN2;
        end
        S_SCAN2: state_q <= S_SCAN2_RD;
        S_FIN: begin
          st_q <= StRun;
          if (rd_rem_q == 16'd0) begin
            compl_q <= compl_q + 1'b1;
            fin_q <= 1'b1;
            turn_q <= diff[15:0];
            state_q <= S_WAIT;
          end else state_q <= S_OUT;
        end
        S_WAIT: begin
          turn_q <= turn_q;
          in_bur_q <= lt || diff[15:0] == 16'd0 ? 16'd0 : diff[15:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          status_o <= st_q;
          slot_index_o <= 4'(slot_q);
          dispatched_tag_o <= (st_q == StRun) ? rd_tag_q : 8'd0;
          slice_length_o <= slice_q;
          level_run_o <= (st_q == StRun) ? lvl_q : 2'd0;
          finished_o <= fin_q;
          turnaround_o <= fin_q ? turn_q : 16'd0;
          waiting_o <= fin_q ? in_bur_q : 16'd0;
          time_now_o <= time_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o)
  `ASSERT_IMPL(a_busy_start, clk_i, rst_ni, (start && !busy) |=> busy)
  `ASSERT_NEVER(a_compl_le_loaded, clk_i, rst_ni, compl_q > loaded_q)
endmodule
